/* src/jet_pkg.sv */
// shared types and constants for the julia escape-time core
package jet_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned Z_W       = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned RAD_W     = 31;
  localparam int unsigned FRAC_W    = 28;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MAG_W     = Z_W;
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned NUM_CELLS = MAG_W / DIGIT_W;
  localparam int unsigned PART_W    = MAG_W + DIGIT_W;
  localparam int unsigned PROD_W    = 2 * MAG_W;

  localparam int unsigned ODD_W      = COORD_W + 1;
  localparam int unsigned OFF_PROD_W = ODD_W + STEP_W;
  localparam int unsigned OFF_W      = OFF_PROD_W - 1;
  localparam int unsigned START_W    = OFF_W + 2;
  localparam int unsigned WIDE_W     = PROD_W + 1;

  localparam logic signed [Z_W-1:0]   RST_ORIGIN_REAL = -32'sd402653184;
  localparam logic signed [Z_W-1:0]   RST_ORIGIN_IMAG = 32'sd268435456;
  localparam logic [STEP_W-1:0]       RST_STEP        = 31'd786432;
  localparam logic signed [Z_W-1:0]   RST_C_REAL      = -32'sd214748365;
  localparam logic signed [Z_W-1:0]   RST_C_IMAG      = 32'sd41875931;
  localparam logic [COUNT_W-1:0]      RST_MAX_ITER    = 16'd256;
  localparam logic [RAD_W-1:0]        RST_RADIUS_SQ   = 31'd67108864;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_REAL = 3'd0,
    REG_ORIGIN_IMAG = 3'd1,
    REG_STEP        = 3'd2,
    REG_C_REAL      = 3'd3,
    REG_C_IMAG      = 3'd4,
    REG_MAX_ITER    = 3'd5,
    REG_RADIUS_SQ   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } jet_state_t;

  typedef struct packed {
    logic              vld;
    logic [MAG_W-1:0]  zr_mag;
    logic [MAG_W-1:0]  zi_mag;
    logic [PROD_W-1:0] rr;
    logic [PROD_W-1:0] ii;
    logic [PROD_W-1:0] ri;
  } jet_lane_t;

endpackage

/* src/julia_escape_time_core.sv */
// top level of the julia escape-time core: control, config registers and cell chain
//
// usage
// - input channel (in_valid/in_ready) takes one pixel item: column and row
// - output channel (out_valid/out_ready) returns one item per pixel: iteration
//   count, escaped flag and the last z, saturated to signed q4.28
// - config registers are written through cfg_we/cfg_index/cfg_wdata while idle
// - one item is worked on at a time; in_ready is high only while the core is free
// - each iteration starts in the issue state and runs through the chain
//   of multiplier cells (one 8-bit digit per cell), the escape test and the next z
//   are formed in the cycle the chain delivers its products
// - the time from accept to out_valid grows with the number of iterations n;
//   the default limit is 256 iterations; the next item is taken only once
//   the previous one has moved into the output register
// - a finished item waits in the output register while the next one is taken;
//   if the receiver stalls, the following item holds in its last state until
//   the output register frees up
// - reset clears control state and loads the config registers with defaults
module julia_escape_time_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [jet_pkg::COORD_W-1:0]            in_column,
  input  logic [jet_pkg::COORD_W-1:0]            in_row,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [jet_pkg::COUNT_W-1:0]            out_iteration_count,
  output logic                                   out_escaped,
  output logic signed [jet_pkg::Z_W-1:0]         out_final_real,
  output logic signed [jet_pkg::Z_W-1:0]         out_final_imag,
  input  logic                                   cfg_we,
  input  logic [jet_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import jet_pkg::*;

  localparam int unsigned SAT_W = START_W;
  localparam logic signed [SAT_W-1:0] ZMAX = SAT_W'(32'sh7FFFFFFF);
  localparam logic signed [SAT_W-1:0] ZMIN = SAT_W'(32'sh80000000);

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SAT_W-1:0] v);
    logic signed [Z_W-1:0] res;
    if (v > ZMAX) begin
      res = ZMAX[Z_W-1:0];
    end else if (v < ZMIN) begin
      res = ZMIN[Z_W-1:0];
    end else begin
      res = v[Z_W-1:0];
    end
    return res;
  endfunction

  // config registers
  logic signed [Z_W-1:0] origin_real_r;
  logic signed [Z_W-1:0] origin_imag_r;
  logic [STEP_W-1:0]     step_r;
  logic signed [Z_W-1:0] c_real_r;
  logic signed [Z_W-1:0] c_imag_r;
  logic [COUNT_W-1:0]    max_iter_r;
  logic [RAD_W-1:0]      radius_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r <= RST_ORIGIN_REAL;
      origin_imag_r <= RST_ORIGIN_IMAG;
      step_r        <= RST_STEP;
      c_real_r      <= RST_C_REAL;
      c_imag_r      <= RST_C_IMAG;
      max_iter_r    <= RST_MAX_ITER;
      radius_sq_r   <= RST_RADIUS_SQ;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_REAL: origin_real_r <= cfg_wdata[Z_W-1:0];
        REG_ORIGIN_IMAG: origin_imag_r <= cfg_wdata[Z_W-1:0];
        REG_STEP:        step_r        <= cfg_wdata[STEP_W-1:0];
        REG_C_REAL:      c_real_r      <= cfg_wdata[Z_W-1:0];
        REG_C_IMAG:      c_imag_r      <= cfg_wdata[Z_W-1:0];
        REG_MAX_ITER:    max_iter_r    <= cfg_wdata[COUNT_W-1:0];
        REG_RADIUS_SQ:   radius_sq_r   <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  jet_state_t            state_r, state_nxt;
  logic [OFF_W-1:0]      off_re_r, off_re_nxt;
  logic [OFF_W-1:0]      off_im_r, off_im_nxt;
  logic signed [Z_W-1:0] zr_r, zr_nxt;
  logic signed [Z_W-1:0] zi_r, zi_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic                  esc_r, esc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_esc_r, out_esc_nxt;
  logic signed [Z_W-1:0] out_re_r, out_re_nxt;
  logic signed [Z_W-1:0] out_im_r, out_im_nxt;

  // start point offsets
  logic [ODD_W-1:0]      odd_col;
  logic [ODD_W-1:0]      odd_row;
  logic [OFF_PROD_W-1:0] prod_col;
  logic [OFF_PROD_W-1:0] prod_row;
  logic signed [START_W-1:0] start_re;
  logic signed [START_W-1:0] start_im;

  assign odd_col  = {in_column, 1'b1};
  assign odd_row  = {in_row, 1'b1};
  assign prod_col = OFF_PROD_W'(odd_col) * OFF_PROD_W'(step_r);
  assign prod_row = OFF_PROD_W'(odd_row) * OFF_PROD_W'(step_r);
  assign start_re = $signed(START_W'(origin_real_r)) + $signed({2'b00, off_re_r});
  assign start_im = $signed(START_W'(origin_imag_r)) - $signed({2'b00, off_im_r});

  // cell chain
  jet_lane_t lane [NUM_CELLS+1];
  jet_lane_t tail;

  assign lane[0] = '{
    vld:    (state_r == ST_ISSUE),
    zr_mag: (zr_r[Z_W-1] ? MAG_W'(-zr_r) : MAG_W'(zr_r)),
    zi_mag: (zi_r[Z_W-1] ? MAG_W'(-zi_r) : MAG_W'(zi_r)),
    rr:     '0,
    ii:     '0,
    ri:     '0
  };

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    jet_cell #(.DIGIT(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (lane[g]),
      .lane_o (lane[g+1])
    );
  end

  assign tail = lane[NUM_CELLS];

  // escape test and next z
  logic [WIDE_W-1:0]        mag;
  logic                     below;
  logic                     go_on;
  logic signed [WIDE_W-1:0] diff;
  logic signed [WIDE_W-1:0] ri_s;
  logic signed [SAT_W-1:0]  re_sum;
  logic signed [SAT_W-1:0]  im_sum;

  assign mag    = {1'b0, tail.rr} + {1'b0, tail.ii};
  assign below  = mag < {2'b00, radius_sq_r, {Z_W{1'b0}}};
  assign go_on  = below && (cnt_r < max_iter_r);
  assign diff   = $signed({1'b0, tail.rr}) - $signed({1'b0, tail.ii});
  assign ri_s   = (zr_r[Z_W-1] ^ zi_r[Z_W-1]) ? -$signed({1'b0, tail.ri})
                                              : $signed({1'b0, tail.ri});
  assign re_sum = SAT_W'(diff >>> FRAC_W) + SAT_W'(c_real_r);
  assign im_sum = SAT_W'(ri_s >>> (FRAC_W - 1)) + SAT_W'(c_imag_r);

  always_comb begin
    state_nxt     = state_r;
    off_re_nxt    = off_re_r;
    off_im_nxt    = off_im_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    cnt_nxt       = cnt_r;
    esc_nxt       = esc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    out_esc_nxt   = out_esc_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          off_re_nxt = prod_col[OFF_PROD_W-1:1];
          off_im_nxt = prod_row[OFF_PROD_W-1:1];
          state_nxt  = ST_START;
        end
      end
      ST_START: begin
        zr_nxt    = sat_z(start_re);
        zi_nxt    = sat_z(start_im);
        cnt_nxt   = '0;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (tail.vld) begin
          if (go_on) begin
            zr_nxt    = sat_z(re_sum);
            zi_nxt    = sat_z(im_sum);
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_ISSUE;
          end else begin
            esc_nxt   = !below;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_r;
          out_esc_nxt   = esc_r;
          out_re_nxt    = zr_r;
          out_im_nxt    = zi_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    off_re_r    <= off_re_nxt;
    off_im_r    <= off_im_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    cnt_r       <= cnt_nxt;
    esc_r       <= esc_nxt;
    out_count_r <= out_count_nxt;
    out_esc_r   <= out_esc_nxt;
    out_re_r    <= out_re_nxt;
    out_im_r    <= out_im_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_escaped         = out_esc_r;
  assign out_final_real      = out_re_r;
  assign out_final_imag      = out_im_r;

endmodule

/* src/jet_cell.sv */
// one multiplier cell: adds one digit's partial products and passes the lane on
module jet_cell #(
  parameter int unsigned DIGIT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  jet_pkg::jet_lane_t lane_i,
  output jet_pkg::jet_lane_t lane_o
);
  import jet_pkg::*;

  localparam int unsigned SHIFT = DIGIT * DIGIT_W;

  logic [DIGIT_W-1:0] dig_r;
  logic [DIGIT_W-1:0] dig_i;
  logic [PART_W-1:0]  p_rr;
  logic [PART_W-1:0]  p_ii;
  logic [PART_W-1:0]  p_ri;
  jet_lane_t          lane_nxt;
  jet_lane_t          lane_r;

  assign dig_r = lane_i.zr_mag[SHIFT +: DIGIT_W];
  assign dig_i = lane_i.zi_mag[SHIFT +: DIGIT_W];
  assign p_rr  = PART_W'(lane_i.zr_mag) * PART_W'(dig_r);
  assign p_ii  = PART_W'(lane_i.zi_mag) * PART_W'(dig_i);
  assign p_ri  = PART_W'(lane_i.zr_mag) * PART_W'(dig_i);

  always_comb begin
    lane_nxt    = lane_i;
    lane_nxt.rr = lane_i.rr + (PROD_W'(p_rr) << SHIFT);
    lane_nxt.ii = lane_i.ii + (PROD_W'(p_ii) << SHIFT);
    lane_nxt.ri = lane_i.ri + (PROD_W'(p_ri) << SHIFT);
  end

  always_ff @(posedge clk) begin
    lane_r.zr_mag <= lane_nxt.zr_mag;
    lane_r.zi_mag <= lane_nxt.zi_mag;
    lane_r.rr     <= lane_nxt.rr;
    lane_r.ii     <= lane_nxt.ii;
    lane_r.ri     <= lane_nxt.ri;
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r.vld <= lane_nxt.vld;
    end
  end

  assign lane_o = lane_r;

endmodule

/* src/jet_checker.sv */
// port-level assertions for the julia escape-time core and their bind
module jet_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [jet_pkg::COUNT_W-1:0]    out_iteration_count,
  input logic                           out_escaped,
  input logic signed [jet_pkg::Z_W-1:0] out_final_real,
  input logic signed [jet_pkg::Z_W-1:0] out_final_imag
);

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_iteration_count)
      && $stable(out_escaped) && $stable(out_final_real) && $stable(out_final_imag))
    else $error("result item changed while stalled");

  // one item at a time: taking an item closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open right after an item was taken");

  // reset leaves the core empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("core not empty after reset");

  // a result never shows up in the cycle right after an item is taken
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too soon after an item was taken");

endmodule

bind julia_escape_time_core jet_checker u_jet_checker (.*);
